// ===== src/acm_pkg.sv =====
// Shared constants, types and register codes for the ADC channel averaging fault monitor.
`default_nettype none
package acm_pkg;

  localparam int NUM_CHANNELS = 12;
  localparam int AVG_SHIFT    = 6;
  localparam int SAMPLE_BITS  = 10;

  localparam int CH_W   = 4;
  localparam int AVG_W  = 10;
  localparam int LIM_W  = 10;
  localparam int CNT_W  = 7;
  localparam int MASK_W = 12;
  localparam int SUM_W  = 16;
  localparam int CMP_W  = (SAMPLE_BITS > LIM_W) ? SAMPLE_BITS : LIM_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [LIM_W-1:0]  LOW_LIMIT_RST   = LIM_W'(20);
  localparam logic [LIM_W-1:0]  HIGH_LIMIT_RST  = LIM_W'(1000);
  localparam logic [CNT_W-1:0]  DEBOUNCE_RST    = CNT_W'(100);
  localparam logic [MASK_W-1:0] FAULT_MASK_RST  = MASK_W'(1805);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT  = 2'd0,
    REG_HIGH_LIMIT = 2'd1,
    REG_DEBOUNCE   = 2'd2,
    REG_FAULT_MASK = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LIM_W-1:0]  low_limit;
    logic [LIM_W-1:0]  high_limit;
    logic [CNT_W-1:0]  debounce_count;
    logic [MASK_W-1:0] fault_enable_mask;
  } cfg_regs_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] oor_cnt;
    logic [CNT_W-1:0] inr_cnt;
  } chan_state_t;

  localparam int STATE_W = $bits(chan_state_t);

endpackage
`default_nettype wire

// ===== src/acm_ifs.sv =====
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none
interface acm_sample_if;
  logic                             valid;
  logic                             ready;
  logic [acm_pkg::SAMPLE_BITS-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface acm_result_if;
  logic                        valid;
  logic                        ready;
  logic [acm_pkg::CH_W-1:0]    channel;
  logic [acm_pkg::AVG_W-1:0]   average;
  logic                        average_updated;
  logic [acm_pkg::MASK_W-1:0]  fault_flags;
  logic                        pass_ready;
  modport source (output valid, output channel, output average, output average_updated,
                  output fault_flags, output pass_ready, input ready);
  modport sink   (input valid, input channel, input average, input average_updated,
                  input fault_flags, input pass_ready, output ready);
endinterface

interface acm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [acm_pkg::CFG_IDX_W-1:0]    index;
  logic [acm_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/acm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module acm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                              clk,
  input  wire                              we,
  input  wire  [$clog2(DEPTH)-1:0]         waddr,
  input  wire  [WIDTH-1:0]                 wdata,
  input  wire                              re,
  input  wire  [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/acm_cfg_regs.sv =====
// Configuration register bank: limits, debounce count and fault enable mask.
`default_nettype none
module acm_cfg_regs (
  input  wire                 clk,
  input  wire                 rst,
  acm_cfg_if.sink             cfg,
  output acm_pkg::cfg_regs_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_limit         <= acm_pkg::LOW_LIMIT_RST;
      regs.high_limit        <= acm_pkg::HIGH_LIMIT_RST;
      regs.debounce_count    <= acm_pkg::DEBOUNCE_RST;
      regs.fault_enable_mask <= acm_pkg::FAULT_MASK_RST;
    end else if (cfg.valid) begin
      unique case (acm_pkg::cfg_reg_t'(cfg.index))
        acm_pkg::REG_LOW_LIMIT:  regs.low_limit <= cfg.data[acm_pkg::LIM_W-1:0];
        acm_pkg::REG_HIGH_LIMIT: regs.high_limit <= cfg.data[acm_pkg::LIM_W-1:0];
        acm_pkg::REG_DEBOUNCE:   regs.debounce_count <= cfg.data[acm_pkg::CNT_W-1:0];
        acm_pkg::REG_FAULT_MASK: regs.fault_enable_mask <= cfg.data[acm_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/adc_channel_average_fault_monitor.sv =====
// Top level: round-robin multichannel ADC averager with per-channel fault debounce.
//
//   port     dir   role
//   samples  sink  one raw sample word per item, channel from internal pointer
//   results  src   channel, average, update flag, fault flags, pass marker
//   cfg      sink  register writes, index 0..3, always ready
//
// One word per cycle sustained while results are taken; each result word passes through
// stage 1 and the output register. Per-channel sum and counters sit in one RAM, read at
// accept and written back as the word leaves stage 1 for the output register; consecutive
// words hit different channels, so no forwarding. Sync reset clears pointer, pass counter,
// fault bits and per-channel valid bits (no clearing pass). A stalled output holds its
// word; one more sample waits in stage 1, then input ready drops until it moves.
`default_nettype none
module adc_channel_average_fault_monitor (
  input  wire            clk,
  input  wire            rst,
  acm_sample_if.sink     samples,
  acm_result_if.source   results,
  acm_cfg_if.sink        cfg
);

  acm_pkg::cfg_regs_t regs;

  acm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // pointer and pass counter
  logic [acm_pkg::CH_W-1:0]      ch_ptr;
  logic [acm_pkg::AVG_SHIFT-1:0] pass_cnt;
  logic                          ptr_wrap;
  logic                          accept;

  // stage 1: RAM data arrives
  logic                           s1_valid;
  logic [acm_pkg::CH_W-1:0]       s1_ch;
  logic [acm_pkg::SAMPLE_BITS-1:0] s1_sample;
  logic                           s1_first;
  logic                           s1_ready_mark;
  logic                           s1_adv;

  logic [acm_pkg::NUM_CHANNELS-1:0] ent_valid;
  logic [acm_pkg::MASK_W-1:0]       fault_bits;
  logic [acm_pkg::MASK_W-1:0]       fault_bits_next;

  logic [acm_pkg::STATE_W-1:0] ram_rdata;
  acm_pkg::chan_state_t        cur;
  acm_pkg::chan_state_t        upd;
  logic [acm_pkg::SUM_W-1:0]   sum_acc;
  logic [acm_pkg::SUM_W-1:0]   sum_sh;
  logic [acm_pkg::CNT_W-1:0]   cnt_inc;
  logic [acm_pkg::CMP_W-1:0]   smp_x;
  logic                        oor;
  logic [acm_pkg::AVG_W-1:0]   avg_next;

  assign ptr_wrap      = (ch_ptr == acm_pkg::CH_W'(acm_pkg::NUM_CHANNELS - 1));
  assign s1_adv        = s1_valid && (!results.valid || results.ready);
  assign samples.ready = !s1_valid || s1_adv;
  assign accept        = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_ptr   <= '0;
      pass_cnt <= '0;
    end else if (accept) begin
      ch_ptr <= ptr_wrap ? '0 : ch_ptr + 1'b1;
      if (ptr_wrap) begin
        pass_cnt <= pass_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch         <= ch_ptr;
      s1_sample     <= samples.sample;
      s1_first      <= (pass_cnt == '0);
      s1_ready_mark <= ptr_wrap && (pass_cnt == '0);
    end
  end

  acm_ram #(
    .WIDTH (acm_pkg::STATE_W),
    .DEPTH (acm_pkg::NUM_CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_ch),
    .wdata (upd),
    .re    (accept),
    .raddr (ch_ptr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur = ent_valid[s1_ch] ? acm_pkg::chan_state_t'(ram_rdata) : '0;
    upd = cur;
    fault_bits_next = fault_bits;

    sum_acc  = cur.sum + acm_pkg::SUM_W'(s1_sample);
    sum_sh   = sum_acc >> acm_pkg::AVG_SHIFT;
    avg_next = s1_first ? sum_sh[acm_pkg::AVG_W-1:0] : '0;
    upd.sum  = s1_first ? '0 : sum_acc;

    smp_x = acm_pkg::CMP_W'(s1_sample);
    oor   = (smp_x < acm_pkg::CMP_W'(regs.low_limit)) ||
            (smp_x > acm_pkg::CMP_W'(regs.high_limit));

    if (oor) begin
      cnt_inc     = cur.oor_cnt + 1'b1;
      upd.inr_cnt = '0;
      upd.oor_cnt = cnt_inc;
      if (cnt_inc >= regs.debounce_count) begin
        upd.oor_cnt = '0;
        if (regs.fault_enable_mask[s1_ch]) begin
          fault_bits_next[s1_ch] = 1'b1;
        end
      end
    end else begin
      cnt_inc     = cur.inr_cnt + 1'b1;
      upd.oor_cnt = '0;
      upd.inr_cnt = cnt_inc;
      if (cnt_inc >= regs.debounce_count) begin
        upd.inr_cnt = '0;
        fault_bits_next[s1_ch] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid  <= '0;
      fault_bits <= '0;
    end else if (s1_adv) begin
      ent_valid[s1_ch] <= 1'b1;
      fault_bits       <= fault_bits_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s1_adv) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      results.channel         <= s1_ch;
      results.average         <= avg_next;
      results.average_updated <= s1_first;
      results.fault_flags     <= fault_bits_next;
      results.pass_ready      <= s1_ready_mark;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_ch) && $stable(s1_sample))
    else $error("stage 1 word lost while stalled");

  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    accept && !ptr_wrap |=> ch_ptr == $past(ch_ptr) + 1'b1)
    else $error("channel pointer skipped");

  a_pass_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.pass_ready |->
      results.channel == acm_pkg::CH_W'(acm_pkg::NUM_CHANNELS - 1) &&
      results.average_updated)
    else $error("pass marker on wrong word");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.average_updated |-> results.average == '0)
    else $error("stale average on non-update word");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    accept && s1_adv |-> ch_ptr != s1_ch)
    else $error("read and write-back hit the same channel");

endmodule
`default_nettype wire
